/* sv/ssc_pkg.sv */
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared constants and codes for the sparse-set component store.
// ----------------------------------------------------------------------------
package ssc_pkg;

    // default sizing
    localparam int DEF_MAX_ENTITIES = 1024;
    localparam int DEF_CAPACITY     = 1024;
    localparam int DEF_DATA_WIDTH   = 32;

    // fixed field widths on the ports
    localparam int MODE_W   = 2;
    localparam int ENTITY_W = 10;
    localparam int SLOT_W   = 10;
    localparam int COMP_W   = 32;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 11;

    // packed stream widths
    localparam int S_DATA_W = 56;  // 52 bits of fields, padded to bytes
    localparam int M_DATA_W = 72;  // 67 bits of fields, padded to bytes

    // operation codes
    typedef enum logic [MODE_W-1:0] {
        MODE_CREATE  = 2'd0,
        MODE_DESTROY = 2'd1,
        MODE_QUERY_E = 2'd2,
        MODE_QUERY_S = 2'd3
    } mode_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 3'd0,
        STAT_ABSENT = 3'd1,
        STAT_FULL   = 3'd2,
        STAT_DUP    = 3'd3,
        STAT_RANGE  = 3'd4
    } status_t;

endpackage

/* sv/ssc_ram.sv */
// ----------------------------------------------------------------------------
// ssc_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ssc_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32,
    parameter int AW    = 10
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* sv/sparse_set_component_store.sv */
// ----------------------------------------------------------------------------
// sparse_set_component_store
// Sparse-set store mapping entity ids to packed slots with swap-remove.
// ----------------------------------------------------------------------------
// Usage:
//   One command item enters on the s_ channel (mode in s_tuser), one result
//   item leaves on the m_ channel for every command. Create appends at the
//   end of the packed area, destroy moves the last slot into the hole, and
//   the two query modes read by entity or by slot.
//   State lives in two synchronous RAMs: a sparse table (valid bit + slot,
//   indexed by entity) and a dense table (entity + component, by slot).
//   From accept to m_tvalid a command passes S_READ and S_FINISH if it is
//   rejected, a create, a slot query or a destroy of the last slot, and
//   also S_FETCH for duplicate create and entity query, or S_REPOINT for a
//   destroy that moves the last slot; the next item is taken once the FSM
//   is back in S_IDLE. The extra state is set by the chain of dependent
//   sparse then dense RAM reads, and on destroy by the second write to
//   the sparse table. After reset a clearing pass zeroes every entry of
//   the sparse table; s_tready stays low until it ends. A stalled m_ side
//   holds the result; one new item may be accepted meanwhile and waits
//   finished in the block until the output register frees up.
// ----------------------------------------------------------------------------
module sparse_set_component_store
    import ssc_pkg::*;
#(
    parameter int MAX_ENTITIES = DEF_MAX_ENTITIES,
    parameter int CAPACITY     = DEF_CAPACITY,
    parameter int DATA_WIDTH   = DEF_DATA_WIDTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    // command items
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // entity_id, slot_index, component
    input  logic [MODE_W-1:0]   s_tuser,  // mode
    // result items
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata   // status, present, slot_out,
                                          // entity_out, component_out, count
);

    localparam int EW       = $clog2(MAX_ENTITIES);
    localparam int SW       = $clog2(CAPACITY);
    localparam int CW       = $clog2(CAPACITY + 1);
    localparam int SPARSE_W = SW + 1;
    localparam int DENSE_W  = EW + DATA_WIDTH;
    localparam int PAD_W    = M_DATA_W - (STATUS_W + 1 + SLOT_W + ENTITY_W + COMP_W + COUNT_W);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_FETCH,
        S_REPOINT,
        S_FINISH
    } state_t;

    state_t state_reg;

    // input fields
    logic [ENTITY_W-1:0]   in_entity;
    logic [SLOT_W-1:0]     in_slot;
    logic [COMP_W-1:0]     in_comp;
    mode_t                 in_mode;

    assign in_entity = s_tdata[ENTITY_W-1:0];
    assign in_slot   = s_tdata[ENTITY_W+SLOT_W-1:ENTITY_W];
    assign in_comp   = s_tdata[ENTITY_W+SLOT_W+COMP_W-1:ENTITY_W+SLOT_W];
    assign in_mode   = mode_t'(s_tuser);

    // captured command
    mode_t                 mode_reg;
    logic [ENTITY_W-1:0]   ent_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [DATA_WIDTH-1:0] comp_reg;
    logic [CW-1:0]         used_reg;
    logic [EW-1:0]         clr_reg;
    logic [SW-1:0]         pos_reg;
    logic [EW-1:0]         moved_reg;

    // pending result
    status_t               res_status_reg;
    logic                  res_present_reg;
    logic [SLOT_W-1:0]     res_slot_reg;
    logic [ENTITY_W-1:0]   res_entity_reg;
    logic [COMP_W-1:0]     res_comp_reg;

    // output register
    logic                  m_tvalid_reg;
    logic [M_DATA_W-1:0]   m_tdata_reg;

    // memory ports
    logic                  sp_we, sp_re;
    logic [EW-1:0]         sp_waddr, sp_raddr;
    logic [SPARSE_W-1:0]   sp_wdata, sp_rdata;
    logic                  dn_we, dn_re;
    logic [SW-1:0]         dn_waddr, dn_raddr;
    logic [DENSE_W-1:0]    dn_wdata, dn_rdata;

    // decoded conditions
    logic                  accept;
    logic                  in_range;
    logic                  sp_valid;
    logic [SW-1:0]         sp_slot;
    logic                  full;
    logic [SW-1:0]         last_slot;
    logic                  at_last;
    logic                  slot_ok;
    logic                  out_free;
    logic [EW-1:0]         ent_idx;

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign in_range  = 32'(ent_reg) < 32'(MAX_ENTITIES);
    assign ent_idx   = EW'(ent_reg);
    assign sp_valid  = sp_rdata[SW];
    assign sp_slot   = sp_rdata[SW-1:0];
    assign full      = (used_reg == CW'(CAPACITY));
    assign last_slot = SW'(used_reg - CW'(1));
    assign at_last   = (sp_slot == last_slot);
    assign slot_ok   = 32'(slot_reg) < 32'(used_reg);
    assign out_free  = !m_tvalid_reg || m_tready;

    ssc_ram #(
        .DEPTH (MAX_ENTITIES),
        .WIDTH (SPARSE_W),
        .AW    (EW)
    ) u_sparse (
        .aclk  (aclk),
        .we    (sp_we),
        .waddr (sp_waddr),
        .wdata (sp_wdata),
        .re    (sp_re),
        .raddr (sp_raddr),
        .rdata (sp_rdata)
    );

    ssc_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (DENSE_W),
        .AW    (SW)
    ) u_dense (
        .aclk  (aclk),
        .we    (dn_we),
        .waddr (dn_waddr),
        .wdata (dn_wdata),
        .re    (dn_re),
        .raddr (dn_raddr),
        .rdata (dn_rdata)
    );

    // memory access control
    always_comb begin
        sp_we    = 1'b0;
        sp_waddr = ent_idx;
        sp_wdata = '0;
        sp_re    = 1'b0;
        sp_raddr = EW'(in_entity);
        dn_we    = 1'b0;
        dn_waddr = sp_slot;
        dn_wdata = dn_rdata;
        dn_re    = 1'b0;
        dn_raddr = (in_mode == MODE_QUERY_S) ? SW'(in_slot) : last_slot;
        case (state_reg)
            S_CLEAR: begin
                sp_we    = 1'b1;
                sp_waddr = clr_reg;
            end
            S_IDLE: begin
                sp_re = accept;
                dn_re = accept;
            end
            S_READ: begin
                dn_raddr = sp_slot;
                if (in_range && sp_valid &&
                    (mode_reg == MODE_CREATE || mode_reg == MODE_QUERY_E)) begin
                    dn_re = 1'b1;
                end else if (mode_reg == MODE_CREATE && in_range && !full) begin
                    // append at the end of the packed area
                    sp_we    = 1'b1;
                    sp_wdata = {1'b1, SW'(used_reg)};
                    dn_we    = 1'b1;
                    dn_waddr = SW'(used_reg);
                    dn_wdata = {ent_idx, comp_reg};
                end else if (mode_reg == MODE_DESTROY && in_range && sp_valid) begin
                    // clear membership, move last slot into the hole
                    sp_we = 1'b1;
                    dn_we = !at_last;
                end
            end
            S_REPOINT: begin
                sp_we    = 1'b1;
                sp_waddr = moved_reg;
                sp_wdata = {1'b1, pos_reg};
            end
            default: begin
            end
        endcase
    end

    // sequencer, result and output registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            used_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // output valid: set when a result loads, cleared when taken
            if (state_reg == S_FINISH && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + EW'(1);
                    if (clr_reg == EW'(MAX_ENTITIES - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        mode_reg  <= in_mode;
                        ent_reg   <= in_entity;
                        slot_reg  <= in_slot;
                        comp_reg  <= DATA_WIDTH'(in_comp);
                        state_reg <= S_READ;
                    end
                end
                S_READ: begin
                    res_status_reg  <= STAT_ABSENT;
                    res_present_reg <= 1'b0;
                    res_slot_reg    <= '0;
                    res_entity_reg  <= '0;
                    res_comp_reg    <= '0;
                    pos_reg         <= sp_slot;
                    moved_reg       <= dn_rdata[DENSE_W-1:DATA_WIDTH];
                    state_reg       <= S_FINISH;
                    case (mode_reg)
                        MODE_CREATE: begin
                            if (in_range && sp_valid) begin
                                res_status_reg <= STAT_DUP;
                                state_reg      <= S_FETCH;
                            end else if (in_range && full) begin
                                res_status_reg <= STAT_FULL;
                            end else if (in_range) begin
                                res_status_reg  <= STAT_OK;
                                res_present_reg <= 1'b1;
                                res_slot_reg    <= SLOT_W'(used_reg);
                                res_entity_reg  <= ent_reg;
                                res_comp_reg    <= COMP_W'(comp_reg);
                                used_reg        <= used_reg + CW'(1);
                            end
                        end
                        MODE_DESTROY: begin
                            if (in_range && sp_valid) begin
                                res_status_reg <= STAT_OK;
                                res_slot_reg   <= SLOT_W'(sp_slot);
                                used_reg       <= used_reg - CW'(1);
                                if (!at_last) begin
                                    res_entity_reg <=
                                        ENTITY_W'(dn_rdata[DENSE_W-1:DATA_WIDTH]);
                                    res_comp_reg   <= COMP_W'(dn_rdata[DATA_WIDTH-1:0]);
                                    state_reg      <= S_REPOINT;
                                end
                            end
                        end
                        MODE_QUERY_E: begin
                            if (in_range && sp_valid) begin
                                res_status_reg <= STAT_OK;
                                state_reg      <= S_FETCH;
                            end
                        end
                        default: begin
                            // slot query
                            res_slot_reg <= slot_reg;
                            if (slot_ok) begin
                                res_status_reg  <= STAT_OK;
                                res_present_reg <= 1'b1;
                                res_entity_reg  <=
                                    ENTITY_W'(dn_rdata[DENSE_W-1:DATA_WIDTH]);
                                res_comp_reg    <= COMP_W'(dn_rdata[DATA_WIDTH-1:0]);
                            end else begin
                                res_status_reg <= STAT_RANGE;
                            end
                        end
                    endcase
                end
                S_FETCH: begin
                    // entity found, component read at its slot
                    res_present_reg <= 1'b1;
                    res_slot_reg    <= SLOT_W'(pos_reg);
                    res_entity_reg  <= ent_reg;
                    res_comp_reg    <= COMP_W'(dn_rdata[DATA_WIDTH-1:0]);
                    state_reg       <= S_FINISH;
                end
                S_REPOINT: begin
                    state_reg <= S_FINISH;
                end
                S_FINISH: begin
                    if (out_free) begin
                        m_tdata_reg  <= {{PAD_W{1'b0}}, COUNT_W'(used_reg), res_comp_reg,
                                         res_entity_reg, res_slot_reg, res_present_reg,
                                         res_status_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
